[hw/rtl/abr_pkg.sv]
`default_nettype none

package abr_pkg;

    localparam int TIME_W     = 32;
    localparam int DUTY_W     = 8;
    localparam int PT_W       = 12;
    localparam int PER_W      = 16;
    localparam int OVR_W      = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int NUM_W      = 32;
    localparam int DEN_W      = 16;

    localparam int FILTER_SHIFT_DEF  = 4;
    localparam int SENSOR_BITS_DEF   = 12;
    localparam int BRIGHT_IS_LOW_DEF = 0;
    localparam int MAX_CATCHUP_DEF   = 32;

    localparam logic [PT_W-1:0]   BRIGHT_RST  = 12'd500;
    localparam logic [PT_W-1:0]   DARK_RST    = 12'd3500;
    localparam logic [DUTY_W-1:0] CEIL_RST    = 8'd255;
    localparam logic [DUTY_W-1:0] FLOOR_RST   = 8'd20;
    localparam logic [DUTY_W-1:0] HYST_RST    = 8'd8;
    localparam logic [PER_W-1:0]  RAMP_RST    = 16'd8;
    localparam logic [PER_W-1:0]  SAMPLE_RST  = 16'd100;
    localparam int                DUTY_MID    = (255 + 20) / 2;
    localparam logic [DUTY_W-1:0] DUTY_RST    = DUTY_W'(DUTY_MID);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BRIGHT   = 3'd0,
        CFG_DARK     = 3'd1,
        CFG_CEIL     = 3'd2,
        CFG_FLOOR    = 3'd3,
        CFG_HYST     = 3'd4,
        CFG_RAMP     = 3'd5,
        CFG_SAMPLE   = 3'd6,
        CFG_OVERRIDE = 3'd7
    } t_cfg_idx;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic load_in;
        logic sample;
        logic map_mul;
        logic want_ceil;
        logic div_map;
        logic map_take;
        logic hyst;
        logic div_ramp;
        logic ramp_take;
        logic ramp_skip;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic due;
        logic span_ok;
        logic ramp_need;
        logic ramp_due;
        logic div_done;
    } t_dp_sts;

endpackage

`default_nettype wire

[hw/rtl/abr_intf.sv]
`default_nettype none

interface abr_in_if #(
    parameter int SENSOR_BITS = abr_pkg::SENSOR_BITS_DEF
);
    import abr_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [TIME_W-1:0]      now_ms;
    logic [SENSOR_BITS-1:0] light_sample;

    modport source (output valid, output now_ms, output light_sample, input ready);
    modport sink   (input valid, input now_ms, input light_sample, output ready);
endinterface

interface abr_out_if;
    import abr_pkg::*;
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] duty;
    logic              duty_updated;
    logic [DUTY_W-1:0] target;

    modport source (output valid, output duty, output duty_updated, output target,
                    input ready);
    modport sink   (input valid, input duty, input duty_updated, input target,
                    output ready);
endinterface

interface abr_cfg_if;
    import abr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/ambient_backlight_regulator.sv]
`default_nettype none

// channel  dir  handshake         word
// i_in     in   valid/ready       now_ms, light_sample
// o_res    out  valid/ready       duty, duty_updated, target
// i_cfg    in   valid/ready (=1)  index, data
//
// one word at a time; each of the two divisions (level map, ramp steps)
// runs in the shared bit-serial divider
// a finished result sits in the output register while the next word is taken
// reset is synchronous; a stalled result holds the block in its last state only
module ambient_backlight_regulator #(
    parameter int FILTER_SHIFT  = abr_pkg::FILTER_SHIFT_DEF,
    parameter int SENSOR_BITS   = abr_pkg::SENSOR_BITS_DEF,
    parameter int BRIGHT_IS_LOW = abr_pkg::BRIGHT_IS_LOW_DEF,
    parameter int MAX_CATCHUP   = abr_pkg::MAX_CATCHUP_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    abr_in_if.sink      i_in,
    abr_out_if.source   o_res,
    abr_cfg_if.sink     i_cfg
);
    import abr_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    cfg_we;

    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid && i_cfg.ready;

    abr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    abr_dp #(
        .FILTER_SHIFT  (FILTER_SHIFT),
        .SENSOR_BITS   (SENSOR_BITS),
        .BRIGHT_IS_LOW (BRIGHT_IS_LOW),
        .MAX_CATCHUP   (MAX_CATCHUP)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_now_ms       (i_in.now_ms),
        .i_light_sample (i_in.light_sample),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .o_duty         (o_res.duty),
        .o_duty_updated (o_res.duty_updated),
        .o_target       (o_res.target)
    );

    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("second word taken while one is in work");

    a_step_needed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.ramp_take |-> w_sts.ramp_need)
        else $error("ramp step applied with duty already at target");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_res.valid || o_res.ready))
        else $error("result register overwritten before it was taken");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> o_res.valid)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

[hw/rtl/abr_div.sv]
`default_nettype none

module abr_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [abr_pkg::NUM_W-1:0]   i_num,
    input  logic [abr_pkg::DEN_W-1:0]   i_den,
    output logic                        o_done,
    output logic [abr_pkg::NUM_W-1:0]   o_quo
);
    import abr_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W:0]   rem_sh;
    logic             fits;

    // restoring division, one quotient bit per cycle
    always_comb begin
        rem_sh = {r_rem, r_quo[NUM_W-1]};
        fits   = rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], fits};
            r_rem <= fits ? DEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

[hw/rtl/abr_dp.sv]
`default_nettype none

module abr_dp #(
    parameter int FILTER_SHIFT  = abr_pkg::FILTER_SHIFT_DEF,
    parameter int SENSOR_BITS   = abr_pkg::SENSOR_BITS_DEF,
    parameter int BRIGHT_IS_LOW = abr_pkg::BRIGHT_IS_LOW_DEF,
    parameter int MAX_CATCHUP   = abr_pkg::MAX_CATCHUP_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  abr_pkg::t_dp_cmd                 i_cmd,
    output abr_pkg::t_dp_sts                 o_sts,
    input  logic [abr_pkg::TIME_W-1:0]       i_now_ms,
    input  logic [SENSOR_BITS-1:0]           i_light_sample,
    input  logic                             i_cfg_we,
    input  logic [abr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [abr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic [abr_pkg::DUTY_W-1:0]       o_duty,
    output logic                             o_duty_updated,
    output logic [abr_pkg::DUTY_W-1:0]       o_target
);
    import abr_pkg::*;

    localparam int ACC_W  = SENSOR_BITS + FILTER_SHIFT;
    localparam int DK_W   = ((SENSOR_BITS > PT_W) ? SENSOR_BITS : PT_W) + 2;
    localparam int SPAN_W = PT_W + 1;
    localparam int RNG_W  = DUTY_W + 1;
    localparam int PROD_W = RNG_W + SPAN_W;
    localparam int MAG_W  = PROD_W - 1;
    localparam int HD_W   = DUTY_W + 2;

    // configuration
    logic [PT_W-1:0]   r_bright, r_dark;
    logic [DUTY_W-1:0] r_ceil, r_floor, r_hyst;
    logic [PER_W-1:0]  r_ramp_per, r_sample_per;
    logic              r_auto;

    // regulator state
    logic [ACC_W-1:0]  r_accum;
    logic              r_primed;
    logic [DUTY_W-1:0] r_target, r_cur;
    logic [TIME_W-1:0] r_next, r_last;
    logic              r_updated;

    // per-word working registers
    logic [TIME_W-1:0]      r_now;
    logic [SENSOR_BITS-1:0] r_raw;
    logic [MAG_W-1:0]       r_prod_mag;
    logic                   r_prod_neg;
    logic [PT_W-1:0]        r_span;
    logic                   r_span_ok;
    logic [DUTY_W-1:0]      r_want;
    logic [DUTY_W-1:0]      r_out_duty, r_out_target;
    logic                   r_out_updated;

    logic [TIME_W-1:0]        since_due;
    logic                     due;
    logic [SENSOR_BITS-1:0]   level;
    logic signed [DK_W-1:0]   lvl_x, bp_x, darkness, span_x;
    logic signed [SPAN_W-1:0] span;
    logic                     span_ok;
    logic [PT_W-1:0]          dk_c;
    logic signed [RNG_W-1:0]  range_d;
    logic signed [PROD_W-1:0] prod, prod_abs;
    logic signed [HD_W-1:0]   hd, hh;
    logic [PER_W-1:0]         period;
    logic [TIME_W-1:0]        elapsed;
    logic                     ramp_need, ramp_due;
    logic                     div_start, div_done;
    logic [NUM_W-1:0]         div_num, div_quo;
    logic [DEN_W-1:0]         div_den;
    logic [DUTY_W-1:0]        quo8, steps, remain, move;
    logic                     up;
    logic [DUTY_W-1:0]        ovr_v;

    always_comb begin
        since_due = r_now - r_next;
        due       = r_auto && !since_due[TIME_W-1];
    end

    // linear map of the filtered level
    always_comb begin
        level = r_accum[FILTER_SHIFT +: SENSOR_BITS];
        lvl_x = signed'({{(DK_W - SENSOR_BITS){1'b0}}, level});
        bp_x  = signed'({{(DK_W - PT_W){1'b0}}, r_bright});
        if (BRIGHT_IS_LOW != 0) begin
            darkness = lvl_x - bp_x;
            span     = signed'({1'b0, r_dark}) - signed'({1'b0, r_bright});
        end else begin
            darkness = bp_x - lvl_x;
            span     = signed'({1'b0, r_bright}) - signed'({1'b0, r_dark});
        end
        span_ok = !span[SPAN_W-1] && (span != '0);
        span_x  = signed'({{(DK_W - SPAN_W){span[SPAN_W-1]}}, span});
        if (darkness < 0) begin
            dk_c = '0;
        end else if (darkness > span_x) begin
            dk_c = span[PT_W-1:0];
        end else begin
            dk_c = darkness[PT_W-1:0];
        end
        range_d  = signed'({1'b0, r_ceil}) - signed'({1'b0, r_floor});
        prod     = PROD_W'(range_d) * PROD_W'(signed'({1'b0, dk_c}));
        prod_abs = prod[PROD_W-1] ? -prod : prod;
    end

    always_comb begin
        hd = signed'({2'b00, r_want}) - signed'({2'b00, r_target});
        hh = signed'({2'b00, r_hyst});
    end

    // ramp
    always_comb begin
        period    = (r_ramp_per == '0) ? PER_W'(1) : r_ramp_per;
        elapsed   = r_now - r_last;
        ramp_need = r_cur != r_target;
        ramp_due  = elapsed >= TIME_W'(period);
        quo8      = div_quo[DUTY_W-1:0];
        steps     = (div_quo > NUM_W'(MAX_CATCHUP)) ? DUTY_W'(MAX_CATCHUP) : quo8;
        up        = r_target > r_cur;
        remain    = up ? (r_target - r_cur) : (r_cur - r_target);
        move      = (steps < remain) ? steps : remain;
    end

    always_comb begin
        div_start = i_cmd.div_map || i_cmd.div_ramp;
        div_num   = i_cmd.div_map ? NUM_W'(r_prod_mag) : elapsed;
        div_den   = i_cmd.div_map ? DEN_W'(r_span) : period;
        ovr_v     = (i_cfg_data[DUTY_W-1:0] > r_ceil) ? r_ceil : i_cfg_data[DUTY_W-1:0];
    end

    abr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright     <= BRIGHT_RST;
            r_dark       <= DARK_RST;
            r_ceil       <= CEIL_RST;
            r_floor      <= FLOOR_RST;
            r_hyst       <= HYST_RST;
            r_ramp_per   <= RAMP_RST;
            r_sample_per <= SAMPLE_RST;
            r_auto       <= 1'b1;
            r_accum      <= '0;
            r_primed     <= 1'b0;
            r_target     <= DUTY_RST;
            r_cur        <= DUTY_RST;
            r_next       <= '0;
            r_last       <= '0;
            r_updated    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_BRIGHT: r_bright     <= i_cfg_data[PT_W-1:0];
                    CFG_DARK:   r_dark       <= i_cfg_data[PT_W-1:0];
                    CFG_CEIL:   r_ceil       <= i_cfg_data[DUTY_W-1:0];
                    CFG_FLOOR:  r_floor      <= i_cfg_data[DUTY_W-1:0];
                    CFG_HYST:   r_hyst       <= i_cfg_data[DUTY_W-1:0];
                    CFG_RAMP:   r_ramp_per   <= i_cfg_data[PER_W-1:0];
                    CFG_SAMPLE: r_sample_per <= i_cfg_data[PER_W-1:0];
                    CFG_OVERRIDE: begin
                        // sign bit set means automatic control
                        if (i_cfg_data[OVR_W-1]) begin
                            r_auto <= 1'b1;
                        end else begin
                            r_auto   <= 1'b0;
                            r_target <= ovr_v;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.sample && due) begin
                r_next   <= r_now + TIME_W'(r_sample_per);
                r_primed <= 1'b1;
                if (!r_primed) begin
                    r_accum <= ACC_W'(r_raw) << FILTER_SHIFT;
                end else begin
                    r_accum <= r_accum - (r_accum >> FILTER_SHIFT) + ACC_W'(r_raw);
                end
            end
            if (i_cmd.hyst && (hd > hh || hd < -hh)) begin
                r_target <= r_want;
            end
            if (i_cmd.ramp_skip) begin
                r_updated <= 1'b0;
                if (!ramp_need) begin
                    r_last <= r_now;
                end
            end
            if (i_cmd.ramp_take) begin
                r_updated <= 1'b1;
                r_last    <= r_now;
                r_cur     <= up ? (r_cur + move) : (r_cur - move);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_now <= i_now_ms;
            r_raw <= i_light_sample;
        end
        if (i_cmd.map_mul) begin
            r_prod_mag <= prod_abs[MAG_W-1:0];
            r_prod_neg <= prod[PROD_W-1];
            r_span     <= span[PT_W-1:0];
            r_span_ok  <= span_ok;
        end
        if (i_cmd.want_ceil) begin
            r_want <= r_ceil;
        end else if (i_cmd.map_take) begin
            r_want <= r_prod_neg ? (r_ceil + quo8) : (r_ceil - quo8);
        end
        if (i_cmd.out_load) begin
            r_out_duty    <= r_cur;
            r_out_updated <= r_updated;
            r_out_target  <= r_target;
        end
    end

    always_comb begin
        o_sts.due       = due;
        o_sts.span_ok   = r_span_ok;
        o_sts.ramp_need = ramp_need;
        o_sts.ramp_due  = ramp_due;
        o_sts.div_done  = div_done;
    end

    assign o_duty         = r_out_duty;
    assign o_duty_updated = r_out_updated;
    assign o_target       = r_out_target;

endmodule

`default_nettype wire

[hw/rtl/abr_ctrl.sv]
`default_nettype none

module abr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  abr_pkg::t_dp_sts  i_sts,
    output abr_pkg::t_dp_cmd  o_cmd
);
    import abr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SAMPLE,
        S_MAP_MUL,
        S_MAP_DIV,
        S_MAP_WAIT,
        S_HYST,
        S_RAMP_CHK,
        S_RAMP_WAIT,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_SAMPLE;
                end
            end
            S_SAMPLE: begin
                o_cmd.sample = 1'b1;
                n_state      = i_sts.due ? S_MAP_MUL : S_RAMP_CHK;
            end
            S_MAP_MUL: begin
                o_cmd.map_mul = 1'b1;
                n_state       = S_MAP_DIV;
            end
            S_MAP_DIV: begin
                if (i_sts.span_ok) begin
                    o_cmd.div_map = 1'b1;
                    n_state       = S_MAP_WAIT;
                end else begin
                    o_cmd.want_ceil = 1'b1;
                    n_state         = S_HYST;
                end
            end
            S_MAP_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.map_take = 1'b1;
                    n_state        = S_HYST;
                end
            end
            S_HYST: begin
                o_cmd.hyst = 1'b1;
                n_state    = S_RAMP_CHK;
            end
            S_RAMP_CHK: begin
                if (i_sts.ramp_need && i_sts.ramp_due) begin
                    o_cmd.div_ramp = 1'b1;
                    n_state        = S_RAMP_WAIT;
                end else begin
                    o_cmd.ramp_skip = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_RAMP_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.ramp_take = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[tb/sv/ambient_backlight_regulator_tb.sv]
`timescale 1ns / 100ps

module ambient_backlight_regulator_tb;
    import abr_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 100;
    localparam int PRINT_CAP     = 100;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              updated;
        logic [DUTY_W-1:0] target;
    } t_duty_word;

    class backlight_scoreboard;
        bit [PT_W-1:0]   bright_pt, dark_pt;
        bit [DUTY_W-1:0] duty_max, duty_min, hyst_band;
        bit [PER_W-1:0]  ramp_ms, sample_ms;
        int              forced_duty;
        bit [31:0]       ema_acc;
        bit              ema_primed;
        bit [DUTY_W-1:0] tgt_duty, cur_duty;
        bit [TIME_W-1:0] sample_deadline, last_step_ms;
        t_duty_word      due_words[$];
        int              errors;

        function new();
            bright_pt = BRIGHT_RST;
            dark_pt = DARK_RST;
            duty_max = CEIL_RST;
            duty_min = FLOOR_RST;
            hyst_band = HYST_RST;
            ramp_ms = RAMP_RST;
            sample_ms = SAMPLE_RST;
            forced_duty = -1;
            ema_acc = 0;
            ema_primed = 1'b0;
            cur_duty = DUTY_W'((int'(duty_max) + int'(duty_min)) / 2);
            tgt_duty = cur_duty;
            sample_deadline = 0;
            last_step_ms = 0;
            errors = 0;
        endfunction

        task report(string what);
            errors++;
            if (errors <= PRINT_CAP)
                $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        function void write_reg(t_cfg_idx idx, bit [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_BRIGHT:   bright_pt = data[PT_W-1:0];
                CFG_DARK:     dark_pt = data[PT_W-1:0];
                CFG_CEIL:     duty_max = data[DUTY_W-1:0];
                CFG_FLOOR:    duty_min = data[DUTY_W-1:0];
                CFG_HYST:     hyst_band = data[DUTY_W-1:0];
                CFG_RAMP:     ramp_ms = data;
                CFG_SAMPLE:   sample_ms = data;
                CFG_OVERRIDE: begin
                    // sign bit set means automatic control again
                    if (data[OVR_W-1]) begin
                        forced_duty = -1;
                    end else begin
                        tgt_duty = (data[DUTY_W-1:0] > duty_max) ? duty_max : data[DUTY_W-1:0];
                        forced_duty = int'(tgt_duty);
                    end
                end
                default: ;
            endcase
        endfunction

        function bit [DUTY_W-1:0] map_duty(int level);
            int darkness, span, swing;
            darkness = int'(bright_pt) - level;
            span = int'(bright_pt) - int'(dark_pt);
            if (span <= 0)
                return duty_max;
            if (darkness < 0)
                darkness = 0;
            if (darkness > span)
                darkness = span;
            swing = int'(duty_max) - int'(duty_min);
            return DUTY_W'(int'(duty_max) - (swing * darkness) / span);
        endfunction

        function void note_tick(bit [TIME_W-1:0] now, bit [PT_W-1:0] light);
            bit [TIME_W-1:0] lag, per, gap, step_n, remain;
            int want, delta;
            bit upd;
            upd = 1'b0;
            lag = now - sample_deadline;
            if (forced_duty < 0 && !lag[TIME_W-1]) begin
                sample_deadline = now + sample_ms;
                if (!ema_primed) begin
                    ema_acc = 32'(light) << FILTER_SHIFT_DEF;
                    ema_primed = 1'b1;
                end else begin
                    ema_acc = ema_acc - (ema_acc >> FILTER_SHIFT_DEF) + 32'(light);
                end
                want = int'(map_duty(int'(ema_acc >> FILTER_SHIFT_DEF)));
                delta = want - int'(tgt_duty);
                if (delta > int'(hyst_band) || delta < -int'(hyst_band))
                    tgt_duty = DUTY_W'(want);
            end
            if (cur_duty != tgt_duty) begin
                per = (ramp_ms == 0) ? 1 : 32'(ramp_ms);
                gap = now - last_step_ms;
                if (gap >= per) begin
                    step_n = gap / per;
                    if (step_n > MAX_CATCHUP_DEF)
                        step_n = MAX_CATCHUP_DEF;
                    last_step_ms = now;
                    if (tgt_duty > cur_duty) begin
                        remain = 32'(tgt_duty) - 32'(cur_duty);
                        cur_duty = cur_duty + DUTY_W'((step_n < remain) ? step_n : remain);
                    end else begin
                        remain = 32'(cur_duty) - 32'(tgt_duty);
                        cur_duty = cur_duty - DUTY_W'((step_n < remain) ? step_n : remain);
                    end
                    upd = 1'b1;
                end
            end else begin
                last_step_ms = now;
            end
            due_words.push_back('{duty: cur_duty, updated: upd, target: tgt_duty});
        endfunction

        task check_word(logic [DUTY_W-1:0] duty, logic updated, logic [DUTY_W-1:0] target);
            t_duty_word want;
            if (due_words.size() == 0) begin
                report($sformatf("word with none pending: duty=%0d upd=%0b target=%0d",
                                 duty, updated, target));
                return;
            end
            want = due_words.pop_front();
            if (duty !== want.duty)
                report($sformatf("duty got %0d want %0d", duty, want.duty));
            if (updated !== want.updated)
                report($sformatf("duty_updated got %0b want %0b", updated, want.updated));
            if (target !== want.target)
                report($sformatf("target got %0d want %0d", target, want.target));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    abr_in_if  in_ch();
    abr_out_if res_ch();
    abr_cfg_if cfg_ch();

    ambient_backlight_regulator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    backlight_scoreboard sb;
    bit              hold_req;
    bit              sink_calm;
    bit              sender_calm;
    bit [TIME_W-1:0] clock_ms;
    int              ambient;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(15, 60);
        return $urandom_range(1, 3);
    endfunction

    function automatic int fit_level(int v);
        if (v < 0)
            return 0;
        if (v > 4095)
            return 4095;
        return v;
    endfunction

    task automatic send_tick(input bit [TIME_W-1:0] now, input bit [PT_W-1:0] light);
        int g;
        in_ch.valid <= 1'b1;
        in_ch.now_ms <= now;
        in_ch.light_sample <= light;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        sb.note_tick(now, light);
        if (!sender_calm && $urandom_range(0, 3) == 0) begin
            g = pick_gap();
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.due_words.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input bit [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        sb.write_reg(idx, data);
    endtask

    // all registers in index order, so an override is clamped to the new ceiling
    task automatic load_config(input int bright, dark, ceil_v, floor_v, hyst, ramp, smp, ovr);
        drain();
        write_reg(CFG_BRIGHT, CFG_DATA_W'(bright));
        write_reg(CFG_DARK, CFG_DATA_W'(dark));
        write_reg(CFG_CEIL, CFG_DATA_W'(ceil_v));
        write_reg(CFG_FLOOR, CFG_DATA_W'(floor_v));
        write_reg(CFG_HYST, CFG_DATA_W'(hyst));
        write_reg(CFG_RAMP, CFG_DATA_W'(ramp));
        write_reg(CFG_SAMPLE, CFG_DATA_W'(smp));
        write_reg(CFG_OVERRIDE, {7'd0, OVR_W'(ovr)});
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_ticks(input int count);
        bit [TIME_W-1:0] advance;
        int pick, sample_v;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                advance = $urandom_range(1, 20);
            else if (pick < 80)
                advance = $urandom_range(21, 300);
            else if (pick < 92)
                advance = $urandom_range(301, 5000);
            else if (pick < 97)
                advance = $urandom; // may land behind the sample deadline
            else
                advance = 0;
            clock_ms += advance;
            ambient = fit_level(ambient + int'($urandom_range(0, 160)) - 80);
            pick = $urandom_range(0, 19);
            if (pick == 0)
                sample_v = 0;
            else if (pick == 1)
                sample_v = 4095;
            else if (pick < 4)
                sample_v = $urandom_range(0, 4095);
            else
                sample_v = fit_level(ambient + int'($urandom_range(0, 60)) - 30);
            send_tick(clock_ms, PT_W'(sample_v));
        end
    endtask

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                stall_left = LONG_HOLD;
                res_ch.ready <= 1'b0;
            end else if (sink_calm || $urandom_range(0, 3) != 0) begin
                res_ch.ready <= 1'b1;
            end else begin
                stall_left = pick_gap() - 1;
                res_ch.ready <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            sb.check_word(res_ch.duty, res_ch.duty_updated, res_ch.target);
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        int bright, ovr;
        sb = new();
        hold_req = 1'b0;
        sink_calm = 1'b0;
        sender_calm = 1'b0;
        ambient = 2000;
        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.now_ms <= '0;
        in_ch.light_sample <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_BRIGHT;
        cfg_ch.data <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: span not positive, so the mapped duty is the ceiling
        send_tick(32'd0, 12'd0);
        send_tick(32'd5, 12'd4095);
        send_tick(32'd8, 12'd100);
        send_tick(32'd1000, 12'd0);
        send_tick(32'd1000, 12'd4095);
        send_tick(32'h7FFF_FFF0, 12'd2048);
        send_tick(32'h8000_0010, 12'd1);
        send_tick(32'hFFFF_FFFF, 12'd4094);
        send_tick(32'h0000_0010, 12'd0);
        send_tick(32'h0000_0200, 12'd4095);

        // zero ramp and sample periods, no hysteresis
        load_config(3500, 500, 100, 20, 0, 0, 0, -1);
        send_tick(32'h201, 12'd4095);
        send_tick(32'h202, 12'd0);
        send_tick(32'h203, 12'd2048);
        send_tick(32'h203, 12'd0);
        send_tick(32'h206, 12'd4095);

        // override above the ceiling gets clamped, sampling stops
        load_config(3500, 500, 100, 20, 8, 4, 100, 255);
        send_tick(32'h208, 12'd0);
        send_tick(32'h20C, 12'd4095);
        send_tick(32'h2D4, 12'd0);
        send_tick(32'h2DB, 12'd4095);
        send_tick(32'h2DC, 12'd2048);
        send_tick(32'h400, 12'd7);
        clock_ms = 32'h400;

        load_config(3500, 500, 255, 20, 8, 8, 100, -1);
        run_ticks(30);
        // long result stall while words keep coming
        hold_req = 1'b1;
        sender_calm = 1'b1;
        run_ticks(12);
        sender_calm = 1'b0;
        run_ticks(35);

        load_config(4095, 0, 255, 0, 0, 1, 1, -1);
        sink_calm = 1'b1;
        sender_calm = 1'b1;
        run_ticks(40);
        sink_calm = 1'b0;
        sender_calm = 1'b0;
        run_ticks(20);
        drain();
        run_ticks(20);

        // floor above ceiling
        load_config(3000, 1000, 40, 200, 3, 3, 20, -1);
        run_ticks(75);

        load_config(4095, 4095, 255, 255, 255, 65535, 65535, -1);
        run_ticks(40);

        load_config(0, 0, 0, 0, 0, 0, 0, -1);
        run_ticks(30);

        repeat (2) begin
            bright = $urandom_range(0, 4095);
            load_config(bright, $urandom_range(0, bright), $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 30), $urandom_range(1, 40),
                        $urandom_range(1, 400), -1);
            clock_ms = $urandom;
            run_ticks(80);
        end

        ovr = $urandom_range(0, 255);
        load_config(3500, 200, 200, 10, 5, 6, 50, ovr);
        run_ticks(60);

        // back to automatic control with a negative code other than all ones
        load_config(3500, 500, 255, 20, 8, 8, 100, -200);
        run_ticks(20);

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.due_words.size() != 0)
            sb.report($sformatf("%0d words never arrived", sb.due_words.size()));
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/abr_pkg.sv
hw/rtl/abr_intf.sv
hw/rtl/abr_div.sv
hw/rtl/abr_dp.sv
hw/rtl/abr_ctrl.sv
hw/rtl/ambient_backlight_regulator.sv
tb/sv/ambient_backlight_regulator_tb.sv
